// File: hw/rtl/swer_pkg.sv
// swer_pkg: shared types and codes for the sliding window event rate core.
// No dependencies.
`default_nettype none
package swer_pkg;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_RATE   = 1'b1;

    localparam logic [31:0] WINDOW_RST = 32'd60000;
    localparam logic [31:0] RATE_RST   = 32'd65536;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  event_id;
        logic [31:0] now_time;
    } t_item;

    typedef struct packed {
        logic [3:0]  event_id_res;
        logic        valid_res;
        logic [31:0] rate;
        logic [6:0]  window_count;
        logic [31:0] total_count;
        logic        last;
    } t_res;

endpackage
`default_nettype wire

// File: hw/rtl/swer_ram.sv
// swer_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module swer_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/sliding_window_event_rate_core.sv
// sliding_window_event_rate_core: per-ID sliding window event rate monitor.
// Depends on swer_pkg and swer_ram (event FIFO storage).
//
// Channel   Direction  Handshake               Payload
// command   in         i_start && !o_busy      i_item (t_item)
// result    out        o_res_valid, one cycle  o_res (t_res)
// config    in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// A transaction passes S_EXP_RD, then S_EXP_CHK while the FIFO is not empty,
// looping back to S_EXP_RD for each expired entry popped, then S_OPER; a list
// then steps S_LIST up to the highest ID in use, one ID per cycle. Expiry is
// bound by the FIFO RAM read: each popped entry costs a read and a compare state.
// Synchronous active-low reset; the FIFO RAM needs no clearing.
// Results cannot be stalled; one per cycle at most.
`default_nettype none
module sliding_window_event_rate_core #(
    parameter int NUM_IDS    = 16,
    parameter int FIFO_DEPTH = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    output logic                 o_busy,
    input  wire  swer_pkg::t_item i_item,
    output logic                 o_res_valid,
    output swer_pkg::t_res       o_res,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_idx,
    input  wire  [31:0]          i_cfg_data
);
    import swer_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam int IW = $clog2(NUM_IDS);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_EXP_RD  = 5'b00010,
        S_EXP_CHK = 5'b00100,
        S_OPER    = 5'b01000,
        S_LIST    = 5'b10000
    } t_state;

    t_state r_state;
    logic [31:0] r_window, r_factor;
    t_item r_item;
    logic [AW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_wc [NUM_IDS];
    logic [31:0] r_tc [NUM_IDS];
    logic r_overflow;
    logic [IW-1:0] r_idx;

    logic [35:0] ram_rdata;
    logic ram_we;
    logic [AW:0] tail_sum;
    logic [AW-1:0] tail;

    logic [IW+3:0] id_wide, fid_wide;
    logic [IW-1:0] id_ix, fid_ix;
    logic id_ok, fid_ok, expired, full;
    logic [NUM_IDS-1:0] nz;
    logic hi_nz;

    // rate of a count
    logic [FW-1:0] rate_cnt;
    logic [FW+31:0] prod, prod_sh;
    logic [31:0] rate_val;

    assign id_wide  = (IW + 4)'(r_item.event_id);
    assign id_ix    = id_wide[IW-1:0];
    assign id_ok    = (32'(r_item.event_id) < 32'(NUM_IDS));
    assign fid_wide = (IW + 4)'(ram_rdata[35:32]);
    assign fid_ix   = fid_wide[IW-1:0];
    assign fid_ok   = (32'(ram_rdata[35:32]) < 32'(NUM_IDS));
    assign expired  = ((r_item.now_time - ram_rdata[31:0]) > r_window);
    assign full     = (32'(r_fill) >= 32'(FIFO_DEPTH));

    assign tail_sum = (AW + 1)'(r_head) + (AW + 1)'(r_fill);
    assign tail = (32'(tail_sum) >= 32'(FIFO_DEPTH)) ?
                  AW'(32'(tail_sum) - 32'(FIFO_DEPTH)) : tail_sum[AW-1:0];
    assign ram_we = (r_state == S_OPER) && (r_item.operation == OP_RECORD)
                    && id_ok && !full;

    swer_ram #(.WIDTH(36), .DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail),
        .i_wdata ({r_item.event_id, r_item.now_time}),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int j = 0; j < NUM_IDS; j++) begin
            nz[j] = (r_wc[j] != '0);
        end
        hi_nz = 1'b0;
        for (int j = 0; j < NUM_IDS; j++) begin
            if (nz[j] && (32'(j) > 32'(r_idx))) begin
                hi_nz = 1'b1;
            end
        end
    end

    assign rate_cnt = (r_state == S_LIST) ? r_wc[r_idx] : (id_ok ? r_wc[id_ix] : '0);
    assign prod     = (FW + 32)'(rate_cnt) * (FW + 32)'(r_factor);
    assign prod_sh  = prod >> 8;
    assign rate_val = (|prod_sh[FW+31:32]) ? 32'hFFFF_FFFF : prod_sh[31:0];

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WINDOW_RST;
            r_factor    <= RATE_RST;
            r_head      <= '0;
            r_fill      <= '0;
            r_overflow  <= 1'b0;
            r_idx       <= '0;
            o_res_valid <= 1'b0;
            for (int j = 0; j < NUM_IDS; j++) begin
                r_wc[j] <= '0;
                r_tc[j] <= '0;
            end
        end else begin
            o_res_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WINDOW: r_window <= i_cfg_data;
                    CFG_RATE:   r_factor <= i_cfg_data;
                    default:    ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_item  <= i_item;
                        r_state <= S_EXP_RD;
                    end
                end
                S_EXP_RD: begin
                    r_state <= (r_fill != '0) ? S_EXP_CHK : S_OPER;
                end
                S_EXP_CHK: begin
                    if (expired) begin
                        if (fid_ok && r_wc[fid_ix] != '0) begin
                            r_wc[fid_ix] <= r_wc[fid_ix] - 1'b1;
                        end
                        r_head  <= (32'(r_head) == 32'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        r_fill  <= r_fill - 1'b1;
                        r_state <= S_EXP_RD;
                    end else begin
                        r_state <= S_OPER;
                    end
                end
                S_OPER: begin
                    r_state <= S_IDLE;
                    unique case (r_item.operation)
                        OP_RECORD: begin
                            if (id_ok && full) begin
                                r_overflow <= 1'b1;
                            end else if (id_ok) begin
                                r_fill       <= r_fill + 1'b1;
                                r_wc[id_ix]  <= r_wc[id_ix] + 1'b1;
                                if (r_tc[id_ix] != 32'hFFFF_FFFF) begin
                                    r_tc[id_ix] <= r_tc[id_ix] + 1'b1;
                                end
                            end
                        end
                        OP_QUERY: begin
                            o_res_valid        <= 1'b1;
                            o_res.event_id_res <= r_item.event_id;
                            o_res.valid_res    <= 1'b1;
                            o_res.rate         <= rate_val;
                            o_res.window_count <= id_ok ? 7'(32'(r_wc[id_ix])) : '0;
                            o_res.total_count  <= id_ok ? r_tc[id_ix] : '0;
                            o_res.last         <= 1'b1;
                        end
                        OP_LIST: begin
                            if (nz == '0) begin
                                o_res_valid        <= 1'b1;
                                o_res.event_id_res <= '0;
                                o_res.valid_res    <= 1'b0;
                                o_res.rate         <= '0;
                                o_res.window_count <= '0;
                                o_res.total_count  <= '0;
                                o_res.last         <= 1'b1;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_LIST;
                            end
                        end
                        default: ;
                    endcase
                end
                S_LIST: begin
                    if (nz[r_idx]) begin
                        o_res_valid        <= 1'b1;
                        o_res.event_id_res <= 4'(32'(r_idx));
                        o_res.valid_res    <= 1'b1;
                        o_res.rate         <= rate_val;
                        o_res.window_count <= 7'(32'(r_wc[r_idx]));
                        o_res.total_count  <= r_tc[r_idx];
                        o_res.last         <= !hi_nz;
                    end
                    if (!hi_nz) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(FIFO_DEPTH))
        else $error("fifo fill beyond depth");
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ($past(r_state) == S_OPER || $past(r_state) == S_LIST))
        else $error("result outside operation or list");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP_CHK) |-> (r_fill != '0))
        else $error("expiry check on empty fifo");
    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |=> r_overflow)
        else $error("overflow flag cleared outside reset");
`endif

endmodule
`default_nettype wire

// File: test/sliding_window_event_rate_core_test.sv
// Self-checking testbench for sliding_window_event_rate_core: directed and random
// record/query/list transactions, checked against an in-bench predictor.
// Depends on swer_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

class rate_scoreboard;
    logic [31:0] window_len;
    logic [31:0] factor;
    logic [3:0]  ev_id [64];
    logic [31:0] ev_time [64];
    int unsigned head;
    int unsigned fill;
    int unsigned win_cnt [16];
    logic [31:0] tot_cnt [16];
    swer_pkg::t_res pending [$];
    int errors;

    function void clear();
        window_len = swer_pkg::WINDOW_RST;
        factor = swer_pkg::RATE_RST;
        head = 0;
        fill = 0;
        foreach (win_cnt[i]) begin
            win_cnt[i] = 0;
            tot_cnt[i] = '0;
        end
        pending.delete();
        errors = 0;
    endfunction

    function logic [31:0] rate_for(int unsigned cnt);
        logic [63:0] p;
        p = (64'(cnt) * 64'(factor)) >> 8;
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function void push_res(logic [3:0] id, logic vld, int unsigned wc, logic [31:0] tc,
                           logic lst);
        swer_pkg::t_res r;
        r.event_id_res = id;
        r.valid_res = vld;
        r.rate = vld ? rate_for(wc) : '0;
        r.window_count = wc[6:0];
        r.total_count = tc;
        r.last = lst;
        pending.push_back(r);
    endfunction

    function void note_item(swer_pkg::t_item it);
        int n;
        logic [31:0] age;
        n = 0;
        while (fill > 0) begin
            age = it.now_time - ev_time[head];
            if (age <= window_len) break;
            if (win_cnt[ev_id[head]] > 0) win_cnt[ev_id[head]]--;
            head = (head + 1) % 64;
            fill--;
        end
        case (it.operation)
            swer_pkg::OP_RECORD: begin
                if (fill < 64) begin
                    ev_id[(head + fill) % 64] = it.event_id;
                    ev_time[(head + fill) % 64] = it.now_time;
                    fill++;
                    win_cnt[it.event_id]++;
                    if (tot_cnt[it.event_id] != 32'hFFFF_FFFF)
                        tot_cnt[it.event_id]++;
                end
            end
            swer_pkg::OP_QUERY:
                push_res(it.event_id, 1'b1, win_cnt[it.event_id], tot_cnt[it.event_id], 1'b1);
            swer_pkg::OP_LIST: begin
                for (int i = 0; i < 16; i++) begin
                    if (win_cnt[i] > 0) begin
                        push_res(4'(i), 1'b1, win_cnt[i], tot_cnt[i], 1'b0);
                        n++;
                    end
                end
                if (n == 0) push_res(4'd0, 1'b0, 0, '0, 1'b1);
                else pending[$].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function void check_res(swer_pkg::t_res got);
        swer_pkg::t_res exp_r;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
        end
        exp_r = pending[0];
        pending.delete(0);
        if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
                $display({"mismatch: exp id %0d v %0d rate %h wc %0d tc %0d last %0d;",
                          " got id %0d v %0d rate %h wc %0d tc %0d last %0d"},
                    exp_r.event_id_res, exp_r.valid_res, exp_r.rate, exp_r.window_count,
                    exp_r.total_count, exp_r.last, got.event_id_res, got.valid_res,
                    got.rate, got.window_count, got.total_count, got.last);
        end
    endfunction
endclass

module sliding_window_event_rate_core_test;
    import swer_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_item i_item = '0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic o_busy;
    logic o_res_valid;
    t_res o_res;

    rate_scoreboard sb;
    int cycles = 0;
    logic [31:0] clock_now = '0;
    logic quiet = 1'b0;

    always #1 i_clk = ~i_clk;

    sliding_window_event_rate_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_res_valid(o_res_valid), .o_res(o_res),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_res_valid) sb.check_res(o_res);
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [3:0] id, logic [31:0] t);
        t_item it;
        it.operation = op;
        it.event_id = id;
        it.now_time = t;
        i_start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_item(it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            i_item <= t_item'(38'({$urandom, $urandom}));
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WINDOW) sb.window_len = val;
        else sb.factor = val;
    endtask

    task automatic random_phase(int count, int max_step);
        logic [1:0] op;
        for (int k = 0; k < count; k++) begin
            clock_now = clock_now + $urandom_range(0, max_step);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: op = OP_RECORD;
                6, 7: op = OP_QUERY;
                8: op = OP_LIST;
                default: op = OP_SPARE;
            endcase
            send_item(op, 4'($urandom), ($urandom_range(0, 30) == 0) ? $urandom : clock_now);
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, queries of unrecorded IDs, extremes
        send_item(OP_LIST, 4'd0, 32'd0);
        send_item(OP_QUERY, 4'd15, 32'd5);
        send_item(OP_RECORD, 4'd0, 32'd10);
        send_item(OP_RECORD, 4'd15, 32'd20);
        send_item(OP_RECORD, 4'd15, 32'd30);
        send_item(OP_SPARE, 4'd7, 32'd40);
        send_item(OP_QUERY, 4'd15, 32'd50);
        send_item(OP_LIST, 4'd9, 32'd60);
        send_item(OP_QUERY, 4'd0, 32'd60070);
        send_item(OP_LIST, 4'd0, 32'hFFFF_FFFF);
        write_cfg(CFG_WINDOW, 32'hFFFF_FFFF);
        write_cfg(CFG_RATE, 32'hFFFF_FFFF);
        for (int k = 0; k < 70; k++) send_item(OP_RECORD, 4'(k), 32'(k));
        send_item(OP_LIST, 4'd0, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 4'd3, 32'hFFFF_FFFF);
        write_cfg(CFG_WINDOW, 32'd1);
        write_cfg(CFG_RATE, 32'd0);
        send_item(OP_LIST, 4'd0, 32'd100);
        send_item(OP_RECORD, 4'd2, 32'd100);
        send_item(OP_QUERY, 4'd2, 32'd101);
        send_item(OP_QUERY, 4'd2, 32'd102);

        write_cfg(CFG_WINDOW, 32'd400);
        write_cfg(CFG_RATE, $urandom);
        random_phase(20, 20);
        write_cfg(CFG_WINDOW, 32'd60000);
        write_cfg(CFG_RATE, 32'd65536);
        random_phase(20, 3000);
        quiet = 1'b1;
        write_cfg(CFG_WINDOW, $urandom_range(1, 100));
        write_cfg(CFG_RATE, $urandom);
        random_phase(15, 40);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/swer_pkg.sv
hw/rtl/swer_ram.sv
hw/rtl/sliding_window_event_rate_core.sv
test/sliding_window_event_rate_core_test.sv
